// ===== src/srbb_pkg.sv =====
package srbb_pkg;

  // fixed point and lane settings
  localparam int FRAC_BITS = 16;
  localparam int LANES     = 4;
  localparam int NUM_BYTES = 4;
  localparam int BLEND_LANES = (LANES < NUM_BYTES) ? LANES : NUM_BYTES;

  // field widths
  localparam int SIZE_W = 10;
  localparam int PCT_W  = 7;
  localparam int DIM_W  = 14;
  localparam int CNT_W  = 3;
  localparam int CTR_W  = 15;
  localparam int PIX_W  = 13;
  localparam int BYTE_W = 8;

  // derived datapath widths
  localparam int RAD_W   = SIZE_W - 1;
  localparam int D2_W    = 2 * RAD_W;
  localparam int DX_W    = CTR_W + 1;
  localparam int ABS_W   = DX_W - 1;
  localparam int SQ_IN_W = D2_W + 2 * FRAC_BITS;
  localparam int ROOT_W  = SQ_IN_W / 2;
  localparam int Q_W     = FRAC_BITS + 1;
  localparam int DEN_W   = Q_W;
  localparam int NUM_W   = Q_W + DEN_W;

  localparam logic [Q_W-1:0] ONE = Q_W'(1) << FRAC_BITS;

  // pipeline depth from accept to result strobe
  localparam int LATENCY = 8 + ROOT_W + 2 * Q_W;

  // config port
  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_BRUSH_SIZE   = 3'd0,
    REG_HARDNESS_PCT = 3'd1,
    REG_OPACITY_PCT  = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4,
    REG_BYTES_IN_USE = 3'd5
  } reg_idx_t;

  // data riding alongside the arithmetic units
  typedef struct packed {
    logic                              paint;
    logic                              full;
    logic [NUM_BYTES-1:0][BYTE_W-1:0]  old;
  } side_t;

endpackage

// ===== src/srbb_isqrt.sv =====
module srbb_isqrt
  import srbb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  logic [SQ_IN_W-1:0] in_x,
  input  side_t              in_side,
  output logic               out_vld,
  output logic [ROOT_W-1:0]  out_root,
  output side_t              out_side
);

  localparam int REM_W = ROOT_W + 3;

  logic [SQ_IN_W-1:0] xs   [ROOT_W+1];
  logic [REM_W-1:0]   rem  [ROOT_W+1];
  logic [ROOT_W-1:0]  root [ROOT_W+1];
  logic               vld  [ROOT_W+1];
  side_t              side [ROOT_W+1];

  assign xs[0]   = in_x;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign vld[0]  = in_vld;
  assign side[0] = in_side;

  // one root bit per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             ge;

    always_comb begin
      cur   = {rem[k][REM_W-3:0], xs[k][SQ_IN_W-1 -: 2]};
      trial = {{(REM_W-ROOT_W-2){1'b0}}, root[k], 2'b01};
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      rem[k+1]  <= ge ? (cur - trial) : cur;
      root[k+1] <= {root[k][ROOT_W-2:0], ge};
      xs[k+1]   <= {xs[k][SQ_IN_W-3:0], 2'b00};
      side[k+1] <= side[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end
  end

  assign out_vld  = vld[ROOT_W];
  assign out_root = root[ROOT_W];
  assign out_side = side[ROOT_W];

endmodule

// ===== src/srbb_div.sv =====
module srbb_div
  import srbb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  side_t            in_side,
  output logic             out_vld,
  output logic [Q_W-1:0]   out_quot,
  output side_t            out_side
);

  logic [DEN_W-1:0] rem  [Q_W+1];
  logic [Q_W-1:0]   lo   [Q_W+1];
  logic [Q_W-1:0]   quo  [Q_W+1];
  logic [DEN_W-1:0] den  [Q_W+1];
  logic             vld  [Q_W+1];
  side_t            side [Q_W+1];

  // upper part of the numerator stays below the divisor for valid words
  assign rem[0]  = in_num[NUM_W-1:Q_W];
  assign lo[0]   = in_num[Q_W-1:0];
  assign quo[0]  = '0;
  assign den[0]  = in_den;
  assign vld[0]  = in_vld;
  assign side[0] = in_side;

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [DEN_W:0] cur;
    logic [DEN_W:0] diff;
    logic           ge;

    always_comb begin
      cur  = {rem[k], lo[k][Q_W-1]};
      diff = cur - {1'b0, den[k]};
      ge   = (cur >= {1'b0, den[k]});
    end

    always_ff @(posedge clk) begin
      rem[k+1]  <= ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
      lo[k+1]   <= {lo[k][Q_W-2:0], 1'b0};
      quo[k+1]  <= {quo[k][Q_W-2:0], ge};
      den[k+1]  <= den[k];
      side[k+1] <= side[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end
  end

  assign out_vld  = vld[Q_W];
  assign out_quot = quo[Q_W];
  assign out_side = side[Q_W];

endmodule

// ===== src/srbb_lane.sv =====
module srbb_lane
  import srbb_pkg::*;
(
  input  logic              clk,
  input  logic [Q_W-1:0]    alpha,
  input  logic [BYTE_W-1:0] old_byte,
  output logic [BYTE_W-1:0] new_byte
);

  logic [BYTE_W-1:0]       room;
  logic [Q_W+BYTE_W-1:0]   prod;
  logic [BYTE_W:0]         sum;

  // move toward white by alpha times the headroom
  always_comb begin
    room = ~old_byte;
    prod = alpha * room;
    sum  = {1'b0, old_byte} + {1'b0, prod[FRAC_BITS +: BYTE_W]};
  end

  always_ff @(posedge clk) begin
    new_byte <= sum[BYTE_W-1:0];
  end

endmodule

// ===== src/soft_round_brush_blend.sv =====
// channel    direction  handshake                  payload
// config     in/out     psel penable pwrite pready paddr pwdata prdata
// pixel      in         start, busy                center_x/y pixel_x/y old_byte0..3
// result     out        done (one-cycle strobe)    new_byte0..3 painted
//
// one pixel word accepted every clock; busy never rises
// between the accept edge and the result strobe lie the 25-stage square root pipeline
// and the two 17-stage dividers, with the numbered stage registers around them
// rst is synchronous: config registers go to their reset values, all valid bits clear
// the receiver cannot stall, so nothing ever backs up inside the pipeline
module soft_round_brush_blend
  import srbb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [CTR_W-1:0] center_x,
  input  logic signed [CTR_W-1:0] center_y,
  input  logic [PIX_W-1:0]        pixel_x,
  input  logic [PIX_W-1:0]        pixel_y,
  input  logic [BYTE_W-1:0]       old_byte0,
  input  logic [BYTE_W-1:0]       old_byte1,
  input  logic [BYTE_W-1:0]       old_byte2,
  input  logic [BYTE_W-1:0]       old_byte3,
  output logic                    done,
  output logic [BYTE_W-1:0]       new_byte0,
  output logic [BYTE_W-1:0]       new_byte1,
  output logic [BYTE_W-1:0]       new_byte2,
  output logic [BYTE_W-1:0]       new_byte3,
  output logic                    painted
);

  // percent to Q1.F via reciprocal multiply, exact for 0..100
  localparam int PCT_SHIFT = 14;
  localparam longint unsigned PCT_MUL_L =
    ((64'd1 << (FRAC_BITS + PCT_SHIFT)) + 64'd99) / 64'd100;
  localparam logic [FRAC_BITS+7:0] PCT_MUL = (FRAC_BITS+8)'(PCT_MUL_L);

  function automatic logic [Q_W-1:0] pct_to_q(input logic [PCT_W-1:0] pct);
    logic [PCT_W-1:0]             p;
    logic [PCT_W+FRAC_BITS+7:0]   prod;
    p    = (pct > PCT_W'(100)) ? PCT_W'(100) : pct;
    prod = p * PCT_MUL;
    return prod[PCT_SHIFT +: Q_W];
  endfunction

  // ---------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------
  logic [SIZE_W-1:0] brush_size;
  logic [PCT_W-1:0]  hardness_pct;
  logic [PCT_W-1:0]  opacity_pct;
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [CNT_W-1:0]  bytes_in_use;

  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      brush_size   <= SIZE_W'(10);
      hardness_pct <= PCT_W'(100);
      opacity_pct  <= PCT_W'(100);
      image_width  <= DIM_W'(8192);
      image_height <= DIM_W'(8192);
      bytes_in_use <= CNT_W'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BRUSH_SIZE:   brush_size   <= pwdata[SIZE_W-1:0];
        REG_HARDNESS_PCT: hardness_pct <= pwdata[PCT_W-1:0];
        REG_OPACITY_PCT:  opacity_pct  <= pwdata[PCT_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[DIM_W-1:0];
        REG_BYTES_IN_USE: bytes_in_use <= pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BRUSH_SIZE:   prdata = 32'(brush_size);
      REG_HARDNESS_PCT: prdata = 32'(hardness_pct);
      REG_OPACITY_PCT:  prdata = 32'(opacity_pct);
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      REG_BYTES_IN_USE: prdata = 32'(bytes_in_use);
      default:          prdata = '0;
    endcase
  end

  // values derived from config, refreshed every cycle; the user must change config
  // only while idle; the block does not enforce this, and stage 0 reads radius directly
  logic [RAD_W-1:0] radius;
  logic [D2_W-1:0]  r2_lim;
  logic [Q_W-1:0]   hard_q;
  logic [Q_W-1:0]   opac_q;
  logic [CNT_W-1:0] blend_cnt;

  assign radius = brush_size[SIZE_W-1:1];

  always_ff @(posedge clk) begin
    r2_lim <= radius * radius;
    hard_q <= pct_to_q(hardness_pct);
    opac_q <= pct_to_q(opacity_pct);
    if (bytes_in_use == '0) begin
      blend_cnt <= CNT_W'(1);
    end else if (bytes_in_use > CNT_W'(BLEND_LANES)) begin
      blend_cnt <= CNT_W'(BLEND_LANES);
    end else begin
      blend_cnt <= bytes_in_use;
    end
  end

  // ---------------------------------------------------------------
  // stage 0: offsets from the centre and image / radius checks
  // ---------------------------------------------------------------
  logic [DX_W-1:0]  dx_c, dy_c;
  logic [ABS_W-1:0] adx_c, ady_c;
  logic             pass_c;

  always_comb begin
    dx_c   = {{(DX_W-PIX_W){1'b0}}, pixel_x} - {{(DX_W-CTR_W){center_x[CTR_W-1]}}, center_x};
    dy_c   = {{(DX_W-PIX_W){1'b0}}, pixel_y} - {{(DX_W-CTR_W){center_y[CTR_W-1]}}, center_y};
    adx_c  = dx_c[DX_W-1] ? ABS_W'(~dx_c + 1'b1) : ABS_W'(dx_c);
    ady_c  = dy_c[DX_W-1] ? ABS_W'(~dy_c + 1'b1) : ABS_W'(dy_c);
    // a pixel index always sits below 8192, so the raw size compares fine
    pass_c = (radius != '0) &&
             ({{(DIM_W-PIX_W){1'b0}}, pixel_x} < image_width) &&
             ({{(DIM_W-PIX_W){1'b0}}, pixel_y} < image_height);
  end

  logic                             v0, v1, v2;
  logic [ABS_W-1:0]                 adx0, ady0;
  logic                             pass0, pass1;
  logic [NUM_BYTES-1:0][BYTE_W-1:0] old0, old1;
  logic [2*ABS_W-1:0]               sqx1, sqy1;

  always_ff @(posedge clk) begin
    adx0  <= adx_c;
    ady0  <= ady_c;
    pass0 <= pass_c;
    old0  <= {old_byte3, old_byte2, old_byte1, old_byte0};
  end

  // stage 1: squares
  always_ff @(posedge clk) begin
    sqx1  <= adx0 * adx0;
    sqy1  <= ady0 * ady0;
    pass1 <= pass0;
    old1  <= old0;
  end

  // stage 2: squared distance against squared radius
  logic [2*ABS_W:0] d2_sum;
  logic [D2_W-1:0]  d2_2;
  side_t            side2;

  assign d2_sum = {1'b0, sqx1} + {1'b0, sqy1};

  always_ff @(posedge clk) begin
    d2_2        <= d2_sum[D2_W-1:0];
    side2.paint <= pass1 && (d2_sum <= {{(2*ABS_W+1-D2_W){1'b0}}, r2_lim});
    side2.full  <= 1'b0;
    side2.old   <= old1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= start & ~busy;
      v1 <= v0;
      v2 <= v1;
    end
  end

  // ---------------------------------------------------------------
  // root of d2 * 2^2F gives sqrt(d2) in Q.F; dividing by the radius then
  // yields exactly floor(sqrt(d2/r2) * 2^F)
  // ---------------------------------------------------------------
  logic              vs;
  logic [ROOT_W-1:0] root_s;
  side_t             side_s;

  srbb_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (v2),
    .in_x     ({d2_2, {(2*FRAC_BITS){1'b0}}}),
    .in_side  (side2),
    .out_vld  (vs),
    .out_root (root_s),
    .out_side (side_s)
  );

  logic           vd1;
  logic [Q_W-1:0] dist_q;
  side_t          side_d1;

  srbb_div u_div_dist (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (vs),
    .in_num   ({{(NUM_W-ROOT_W){1'b0}}, root_s}),
    .in_den   ({{(DEN_W-RAD_W){1'b0}}, radius}),
    .in_side  (side_s),
    .out_vld  (vd1),
    .out_quot (dist_q),
    .out_side (side_d1)
  );

  // ---------------------------------------------------------------
  // stage 3: hardness knee; past it alpha falls linearly to zero at 1
  // ---------------------------------------------------------------
  logic [Q_W-1:0]   dist_c;
  logic [Q_W-1:0]   over_c;
  logic             v3;
  logic [NUM_W-1:0] num3;
  logic [DEN_W-1:0] den3;
  side_t            side3;

  always_comb begin
    dist_c = (dist_q > ONE) ? ONE : dist_q;
    over_c = dist_c - hard_q;
  end

  always_ff @(posedge clk) begin
    num3       <= {{(NUM_W-Q_W-FRAC_BITS){1'b0}}, over_c, {FRAC_BITS{1'b0}}};
    den3       <= ONE - hard_q;
    side3.paint <= side_d1.paint;
    side3.full  <= (hard_q >= ONE) || (dist_c <= hard_q);
    side3.old   <= side_d1.old;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= vd1;
    end
  end

  logic           vd2;
  logic [Q_W-1:0] fall_q;
  side_t          side_d2;

  srbb_div u_div_fall (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (v3),
    .in_num   (num3),
    .in_den   (den3),
    .in_side  (side3),
    .out_vld  (vd2),
    .out_quot (fall_q),
    .out_side (side_d2)
  );

  // stage 4: falloff alpha; stage 5: scale by opacity
  logic             v4, v5, v6;
  logic [Q_W-1:0]   alpha4;
  logic [2*Q_W-1:0] prod5;
  logic [Q_W-1:0]   alpha5;
  side_t            side4, side5, side6;

  always_ff @(posedge clk) begin
    alpha4 <= side_d2.full ? ONE : (ONE - fall_q);
    side4  <= side_d2;
    alpha5 <= prod5[FRAC_BITS +: Q_W];
    side5  <= side4;
    side6  <= side5;
  end

  assign prod5 = alpha4 * opac_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v4 <= vd2;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // ---------------------------------------------------------------
  // stage 6: one blend lane per channel byte
  // ---------------------------------------------------------------
  logic [BYTE_W-1:0] lane_new [BLEND_LANES];

  for (genvar i = 0; i < BLEND_LANES; i++) begin : g_lane
    srbb_lane u_lane (
      .clk      (clk),
      .alpha    (alpha5),
      .old_byte (side5.old[i]),
      .new_byte (lane_new[i])
    );
  end

  // ---------------------------------------------------------------
  // stage 7: merge lanes; unblended or unpainted bytes pass through
  // ---------------------------------------------------------------
  logic [NUM_BYTES-1:0][BYTE_W-1:0] out_bytes;

  for (genvar i = 0; i < NUM_BYTES; i++) begin : g_merge
    if (i < BLEND_LANES) begin : g_blend
      always_ff @(posedge clk) begin
        out_bytes[i] <= (side6.paint && (CNT_W'(i) < blend_cnt)) ?
                        lane_new[i] : side6.old[i];
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        out_bytes[i] <= side6.old[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    painted <= side6.paint;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v6;
    end
  end

  assign new_byte0 = out_bytes[0];
  assign new_byte1 = out_bytes[1];
  assign new_byte2 = out_bytes[2];
  assign new_byte3 = out_bytes[3];

endmodule

// ===== src/srbb_checker.sv =====
module srbb_checker
  import srbb_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [BYTE_W-1:0] old_byte0,
  input logic [BYTE_W-1:0] old_byte1,
  input logic [BYTE_W-1:0] old_byte2,
  input logic [BYTE_W-1:0] old_byte3,
  input logic [BYTE_W-1:0] new_byte0,
  input logic [BYTE_W-1:0] new_byte1,
  input logic [BYTE_W-1:0] new_byte2,
  input logic [BYTE_W-1:0] new_byte3,
  input logic              painted
);

  // every accepted word comes out after the fixed pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result strobe missing after accept");

  // blending only ever moves a byte toward white
  a_monotone: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY
      (new_byte0 >= $past(old_byte0, LATENCY)) &&
      (new_byte1 >= $past(old_byte1, LATENCY)) &&
      (new_byte2 >= $past(old_byte2, LATENCY)) &&
      (new_byte3 >= $past(old_byte3, LATENCY)))
    else $error("byte decreased");

  // unpainted pixels pass all bytes through
  a_passthru: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY
      (painted ||
       ((new_byte0 == $past(old_byte0, LATENCY)) &&
        (new_byte1 == $past(old_byte1, LATENCY)) &&
        (new_byte2 == $past(old_byte2, LATENCY)) &&
        (new_byte3 == $past(old_byte3, LATENCY)))))
    else $error("unpainted pixel changed");

endmodule

bind soft_round_brush_blend srbb_checker u_srbb_checker (.*);

// ===== dv/tb_soft_round_brush_blend.sv =====
`timescale 1ns / 100ps

module tb_soft_round_brush_blend;
  import srbb_pkg::*;

  // image bound that the predictor clamps width and height to
  localparam int MAX_DIM = 8192;
  // mapped registers, plus one unmapped index that writes must leave alone
  localparam int NUM_REGS = 6;
  localparam int SPARE_REG = 7;
  // cycles with no word accepted either way before the run is declared hung;
  // the worst quiet stretch is a phase change (drain, register traffic)
  localparam int STALL_LIMIT = 2000;

  // one pixel word as it goes into the block
  typedef struct packed {
    logic signed [CTR_W-1:0]          cx;
    logic signed [CTR_W-1:0]          cy;
    logic [PIX_W-1:0]                 px;
    logic [PIX_W-1:0]                 py;
    logic [NUM_BYTES-1:0][BYTE_W-1:0] old;
  } pixel_word_t;

  // one blended word as it comes out
  typedef struct packed {
    logic [NUM_BYTES-1:0][BYTE_W-1:0] bytes;
    logic                             painted;
  } blend_word_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [CTR_W-1:0] center_x = '0;
  logic signed [CTR_W-1:0] center_y = '0;
  logic [PIX_W-1:0]        pixel_x = '0;
  logic [PIX_W-1:0]        pixel_y = '0;
  logic [BYTE_W-1:0]       old_byte0 = '0;
  logic [BYTE_W-1:0]       old_byte1 = '0;
  logic [BYTE_W-1:0]       old_byte2 = '0;
  logic [BYTE_W-1:0]       old_byte3 = '0;
  logic                    done;
  logic [BYTE_W-1:0]       new_byte0;
  logic [BYTE_W-1:0]       new_byte1;
  logic [BYTE_W-1:0]       new_byte2;
  logic [BYTE_W-1:0]       new_byte3;
  logic                    painted;

  // shadow of the brush registers, kept masked to each register's width
  logic [31:0]   cfg_regs [NUM_REGS];

  pixel_word_t   pending_pixels [$];   // words waiting for the driver
  blend_word_t   expected_blends [$];  // predicted words, oldest first
  pixel_word_t   cur_pixel;            // word currently on the input ports
  int            n_queued = 0;
  int            n_accepted = 0;
  int            gap_left = 0;
  int            steady_left = 0;
  int            bad_results = 0;
  int            bad_reads = 0;

  soft_round_brush_blend u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .start     (start),
    .busy      (busy),
    .center_x  (center_x),
    .center_y  (center_y),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .old_byte0 (old_byte0),
    .old_byte1 (old_byte1),
    .old_byte2 (old_byte2),
    .old_byte3 (old_byte3),
    .done      (done),
    .new_byte0 (new_byte0),
    .new_byte1 (new_byte1),
    .new_byte2 (new_byte2),
    .new_byte3 (new_byte3),
    .painted   (painted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // blend predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] reg_mask(input int idx);
    case (idx)
      REG_BRUSH_SIZE:   return (32'd1 << SIZE_W) - 1;
      REG_HARDNESS_PCT: return (32'd1 << PCT_W) - 1;
      REG_OPACITY_PCT:  return (32'd1 << PCT_W) - 1;
      REG_IMAGE_WIDTH:  return (32'd1 << DIM_W) - 1;
      REG_IMAGE_HEIGHT: return (32'd1 << DIM_W) - 1;
      REG_BYTES_IN_USE: return (32'd1 << CNT_W) - 1;
      default:          return 32'd0;
    endcase
  endfunction

  // floor of the square root, one result bit at a time from the top
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // per cent to unsigned fraction, saturating above 100
  function automatic longint unsigned pct_to_frac(input logic [31:0] pct);
    longint unsigned p;
    p = (pct > 100) ? 100 : pct;
    return (p << FRAC_BITS) / 100;
  endfunction

  function automatic int clamp_dim(input logic [31:0] dim);
    return (dim > MAX_DIM) ? MAX_DIM : int'(dim);
  endfunction

  function automatic blend_word_t predict_blend(input pixel_word_t p);
    blend_word_t     r;
    longint signed   dx;
    longint signed   dy;
    longint unsigned one;
    longint unsigned radius;
    longint unsigned d2;
    longint unsigned r2;
    longint unsigned norm_dist;
    longint unsigned hq;
    longint unsigned op;
    longint unsigned alpha;
    longint unsigned ob;
    int              lanes;
    r.bytes   = p.old;
    r.painted = 1'b0;
    one    = 64'd1 << FRAC_BITS;
    radius = cfg_regs[REG_BRUSH_SIZE] / 2;
    // no brush, or pixel outside the image: word passes through
    if (radius == 0 || p.px >= clamp_dim(cfg_regs[REG_IMAGE_WIDTH]) ||
        p.py >= clamp_dim(cfg_regs[REG_IMAGE_HEIGHT]))
      return r;
    dx = longint'(p.px) - longint'($signed(p.cx));
    dy = longint'(p.py) - longint'($signed(p.cy));
    d2 = dx * dx + dy * dy;
    r2 = radius * radius;
    if (d2 > r2) return r;
    // distance over radius: sqrt of d2/r2 scaled by 2^(2F), floored exactly
    norm_dist = floor_sqrt((d2 << (2 * FRAC_BITS)) / r2);
    if (norm_dist > one) norm_dist = one;
    hq = pct_to_frac(cfg_regs[REG_HARDNESS_PCT]);
    op = pct_to_frac(cfg_regs[REG_OPACITY_PCT]);
    // full strength inside the hard core, linear falloff out to the rim
    alpha = one;
    if (hq < one && norm_dist > hq)
      alpha = one - (((norm_dist - hq) << FRAC_BITS) / (one - hq));
    alpha = (alpha * op) >> FRAC_BITS;
    lanes = cfg_regs[REG_BYTES_IN_USE];
    if (lanes == 0) lanes = 1;
    if (lanes > BLEND_LANES) lanes = BLEND_LANES;
    for (int i = 0; i < lanes; i++) begin
      ob = p.old[i];
      r.bytes[i] = BYTE_W'(ob + ((alpha * (255 - ob)) >> FRAC_BITS));
    end
    r.painted = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // pixel driver: one word per accept, random gaps between words
  // ---------------------------------------------------------------------------

  // mostly back to back or short gaps, a few long ones, and now and then a
  // steady run with no gaps at all
  function automatic int pick_gap();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      steady_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      // word taken at this edge: predict its blend now, config is stable
      if (start && !busy) begin
        expected_blends = {expected_blends, predict_blend(cur_pixel)};
        n_accepted++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          cur_pixel = pending_pixels.pop_front();
          center_x  <= cur_pixel.cx;
          center_y  <= cur_pixel.cy;
          pixel_x   <= cur_pixel.px;
          pixel_y   <= cur_pixel.py;
          old_byte0 <= cur_pixel.old[0];
          old_byte1 <= cur_pixel.old[1];
          old_byte2 <= cur_pixel.old[2];
          old_byte3 <= cur_pixel.old[3];
          start     <= 1'b1;
          gap_left  = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: every strobe is checked against the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_mon
    blend_word_t seen;
    blend_word_t want;
    if (!rst && done) begin
      seen.bytes   = {new_byte3, new_byte2, new_byte1, new_byte0};
      seen.painted = painted;
      if (expected_blends.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual bytes %h painted %b",
                 $time, seen.bytes, seen.painted);
        bad_results++;
      end else begin
        want = expected_blends.pop_front();
        for (int i = 0; i < NUM_BYTES; i++) begin
          if (seen.bytes[i] !== want.bytes[i]) begin
            $display("%0t: new_byte%0d mismatch, expected %h actual %h",
                     $time, i, want.bytes[i], seen.bytes[i]);
            bad_results++;
          end
        end
        if (seen.painted !== want.painted) begin
          $display("%0t: painted mismatch, expected %b actual %b",
                   $time, want.painted, seen.painted);
          bad_results++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run if no word moves for too long
  // ---------------------------------------------------------------------------

  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) stall = 0;
      else stall++;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // register access and stimulus
  // ---------------------------------------------------------------------------

  // setup cycle, access cycle; the write lands on the edge closing the access
  task automatic write_reg(input int idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < NUM_REGS) cfg_regs[idx] = val & reg_mask(idx);
  endtask

  // read every mapped register back; prdata is sampled mid access cycle
  task automatic check_regs();
    logic [31:0] got;
    for (int idx = 0; idx < NUM_REGS; idx++) begin
      @(posedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_W'(idx * 4);
      @(posedge clk);
      penable <= 1'b1;
      @(negedge clk);
      got = prdata;
      @(posedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== cfg_regs[idx]) begin
        $display("%0t: register %0d readback, expected %h actual %h",
                 $time, idx, cfg_regs[idx], got);
        bad_reads++;
      end
    end
  endtask

  task automatic program_brush(input int size, input int hard, input int opac,
                               input int width, input int height, input int nbytes);
    write_reg(REG_BRUSH_SIZE, size);
    write_reg(REG_HARDNESS_PCT, hard);
    write_reg(REG_OPACITY_PCT, opac);
    write_reg(REG_IMAGE_WIDTH, width);
    write_reg(REG_IMAGE_HEIGHT, height);
    write_reg(REG_BYTES_IN_USE, nbytes);
    check_regs();
  endtask

  task automatic push_pixel(input int cx, input int cy, input int px, input int py,
                            input int b0, input int b1, input int b2, input int b3);
    pixel_word_t p;
    p.cx     = CTR_W'(cx);
    p.cy     = CTR_W'(cy);
    p.px     = PIX_W'(px);
    p.py     = PIX_W'(py);
    p.old[0] = BYTE_W'(b0);
    p.old[1] = BYTE_W'(b1);
    p.old[2] = BYTE_W'(b2);
    p.old[3] = BYTE_W'(b3);
    pending_pixels = {pending_pixels, p};
    n_queued++;
  endtask

  // byte values lean toward the ends of the range
  function automatic int random_byte();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // mostly pixels inside the image near the dab centre, so the falloff gets
  // exercised; the rest sit on the image edge, anywhere, or far off
  task automatic add_random_pixels(input int count);
    int kind;
    int w_lim;
    int h_lim;
    int reach;
    int px;
    int py;
    int cx;
    int cy;
    for (int k = 0; k < count; k++) begin
      kind  = $urandom_range(0, 99);
      w_lim = clamp_dim(cfg_regs[REG_IMAGE_WIDTH]);
      h_lim = clamp_dim(cfg_regs[REG_IMAGE_HEIGHT]);
      reach = int'(cfg_regs[REG_BRUSH_SIZE] / 2) + 2;
      if (kind < 80 && w_lim > 0 && h_lim > 0) begin
        px = $urandom_range(0, w_lim - 1);
        py = $urandom_range(0, h_lim - 1);
      end else if (kind < 85) begin
        // first column just past the right edge, or the last column at the bound
        px = (w_lim < MAX_DIM) ? w_lim : MAX_DIM - 1;
        py = (h_lim > 0) ? $urandom_range(0, h_lim - 1) : 0;
      end else begin
        px = $urandom_range(0, MAX_DIM - 1);
        py = $urandom_range(0, MAX_DIM - 1);
      end
      if (kind < 92) begin
        cx = px + int'($urandom_range(0, 2 * reach)) - reach;
        cy = py + int'($urandom_range(0, 2 * reach)) - reach;
      end else begin
        cx = $urandom();
        cy = $urandom();
      end
      push_pixel(cx, cy, px, py, random_byte(), random_byte(), random_byte(),
                 random_byte());
    end
  endtask

  // holds off the sender until every accepted word has produced its result
  task automatic drain();
    while (n_accepted != n_queued || expected_blends.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int size, input int hard, input int opac,
                           input int width, input int height, input int nbytes,
                           input int count);
    program_brush(size, hard, opac, width, height, nbytes);
    add_random_pixels(count);
    drain();
  endtask

  initial begin
    // reset values of the brush registers
    cfg_regs[REG_BRUSH_SIZE]   = 10;
    cfg_regs[REG_HARDNESS_PCT] = 100;
    cfg_regs[REG_OPACITY_PCT]  = 100;
    cfg_regs[REG_IMAGE_WIDTH]  = 8192;
    cfg_regs[REG_IMAGE_HEIGHT] = 8192;
    cfg_regs[REG_BYTES_IN_USE] = 1;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_regs();
    // write to an unmapped index must not disturb anything
    write_reg(SPARE_REG, $urandom());

    // directed: radius 5, half hard core, all four bytes blended
    program_brush(10, 50, 100, 8192, 8192, 4);
    push_pixel(100, 100, 100, 100, 0, 255, 128, 1);     // dead centre
    push_pixel(100, 100, 102, 100, 10, 20, 30, 40);     // inside hard core
    push_pixel(100, 100, 103, 100, 10, 20, 30, 40);     // on the falloff
    push_pixel(100, 100, 105, 100, 0, 0, 0, 0);         // exactly on the rim
    push_pixel(100, 100, 103, 104, 7, 77, 177, 254);    // rim on a diagonal
    push_pixel(100, 100, 104, 104, 0, 0, 0, 0);         // just beyond the rim
    push_pixel(-16384, -16384, 0, 0, 0, 0, 0, 0);       // most negative centre
    push_pixel(16383, 16383, 8191, 8191, 255, 255, 255, 255);
    push_pixel(8191, 8191, 8191, 8191, 0, 0, 0, 0);     // far corner, painted
    push_pixel(0, 0, 0, 0, 255, 255, 255, 255);         // already white
    push_pixel(-3, 0, 0, 0, 1, 2, 3, 4);                // centre left of image
    push_pixel(8194, 8191, 8191, 8191, 200, 100, 50, 0);
    push_pixel(-1, -1, 2, 2, 99, 98, 97, 96);
    drain();

    // widest brush, no hard core
    program_brush(1023, 0, 100, 8192, 8192, 4);
    push_pixel(0, 0, 511, 0, 0, 0, 0, 0);               // rim of the widest brush
    push_pixel(0, 0, 511, 1, 0, 0, 0, 0);               // just past it
    push_pixel(0, 0, 0, 0, 0, 64, 128, 192);
    push_pixel(8702, 8191, 8191, 8191, 5, 5, 5, 5);
    add_random_pixels(120);
    drain();

    run_phase(10, 100, 100, 8192, 8192, 1, 120);  // reset settings, written
    run_phase(0, 50, 50, 8192, 8192, 2, 60);      // zero radius
    run_phase(1, 50, 50, 8192, 8192, 2, 30);      // radius rounds to zero
    run_phase(2, 127, 127, 8192, 8192, 7, 80);    // per cent over 100, byte count 7
    run_phase(64, 37, 73, 100, 50, 3, 150);       // small image
    run_phase(200, 80, 0, 16383, 8193, 0, 100);   // zero opacity, oversized image
    run_phase(33, 99, 1, 0, 8192, 5, 60);         // zero width paints nothing
    run_phase(500, 1, 100, 1, 1, 4, 60);          // one pixel image
    repeat (4) begin
      run_phase($urandom_range(0, 1023), $urandom_range(0, 127), $urandom_range(0, 127),
                $urandom_range(0, 16383), $urandom_range(0, 16383), $urandom_range(0, 7),
                70);
    end

    drain();
    // catch any stray strobes after the last expected word
    repeat (LATENCY + 8) @(posedge clk);
    if (bad_results == 0 && bad_reads == 0 && expected_blends.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
